@@ src/lvpr_pkg.sv @@
// Package for the limb vertex pivot rotate block: defaults, pivots, sine table entries.
package lvpr_pkg;

  // Default parameter values
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int COORD_FRAC_BITS_DEF  = 12;

  // Angle and trig formats
  localparam int ANGLE_W   = 16;
  localparam int QUAD_LSB  = 14;         // angle bits 15..14 pick the quadrant
  localparam int TRIG_W    = 15;         // table magnitude, Q1.14, up to 16384
  localparam int TRIG_FRAC = 14;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

  // Half pi in Q30, used to place table entries
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Body parts
  localparam int PART_W    = 3;
  localparam int NUM_PARTS = 6;
  localparam logic [PART_W-1:0] PART_HEAD = 3'd0;

  // Joint pivots in eighths of a model unit; every pivot has zero Z
  localparam int EIGHTH_W = 5;
  localparam logic signed [EIGHTH_W-1:0] PIVOT_X_EIGHTHS [NUM_PARTS] =
    '{5'sd0, 5'sd0, 5'sd3, -5'sd3, 5'sd1, -5'sd1};
  localparam logic signed [EIGHTH_W-1:0] PIVOT_Y_EIGHTHS [NUM_PARTS] =
    '{5'sd10, 5'sd0, 5'sd10, 5'sd10, 5'sd5, 5'sd5};

  // One quarter-wave entry: truncating Q30 Horner series, rounded to Q1.14
  function automatic logic [TRIG_W-1:0] sine_entry(input logic [63:0] x);
    logic [63:0] one;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] q;
    one = 64'd1 << 30;
    x2  = (x * x) >> 30;
    acc = one;
    acc = one - ((x2 * acc) >> 30) / 64'd156;
    acc = one - ((x2 * acc) >> 30) / 64'd110;
    acc = one - ((x2 * acc) >> 30) / 64'd72;
    acc = one - ((x2 * acc) >> 30) / 64'd42;
    acc = one - ((x2 * acc) >> 30) / 64'd20;
    acc = one - ((x2 * acc) >> 30) / 64'd6;
    s   = (x * acc) >> 30;
    q   = (s * 64'd16384 + (64'd1 << 29)) >> 30;
    return q[TRIG_W-1:0];
  endfunction

endpackage

@@ src/lvpr_sine_rom.sv @@
// Quarter-wave sine table with registered read.
module lvpr_sine_rom #(
  parameter int DEPTH = lvpr_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(DEPTH+1)-1:0]       idx,
  output logic [lvpr_pkg::TRIG_W-1:0]      mag
);
  import lvpr_pkg::*;

  logic [TRIG_W-1:0] sine_q [DEPTH+1];

  // Table contents are fixed at elaboration
  for (genvar k = 0; k <= DEPTH; k++) begin : g_ent
    localparam logic [63:0] XK = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
    assign sine_q[k] = sine_entry(XK);
  end

  always_ff @(posedge clk) begin
    mag <= sine_q[idx];
  end

endmodule

@@ src/limb_vertex_pivot_rotate_core.sv @@
// Top level: vertex rotation about a body-part pivot, six-stage pipeline.
// Throughput: one word per clock; busy is always low, as every stage moves each cycle.
// Stage 1 is the sine table read; stages 2/4 hold the pitch/yaw products.
// Reset clears the valid bits of every stage; data registers are not reset.
// Results are shown for one cycle on done; the receiver cannot stall.
module limb_vertex_pivot_rotate_core #(
  parameter int SINE_TABLE_DEPTH = lvpr_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COORD_FRAC_BITS  = lvpr_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lvpr_pkg::PART_W-1:0]           part,
  input  logic signed [lvpr_pkg::ANGLE_W-1:0]   pitch_angle,
  input  logic signed [lvpr_pkg::ANGLE_W-1:0]   yaw_angle,
  input  logic signed [15:0]                    x_in,
  input  logic signed [15:0]                    y_in,
  input  logic signed [15:0]                    z_in,
  output logic                                  done,
  output logic signed [15:0]                    x_out,
  output logic signed [15:0]                    y_out,
  output logic signed [15:0]                    z_out
);
  import lvpr_pkg::*;

  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = QUAD_LSB + IW;
  localparam int PIV_W = COORD_FRAC_BITS + 2;
  localparam int CW    = ((PIV_W > 16) ? PIV_W : 16) + 1;  // after pivot subtract
  localparam int RW    = CW + 2;                           // after both rotations
  localparam int PRW   = RW + TRIG_W + 1;                  // one product
  localparam int SW    = PRW + 1;                          // sum of two products
  localparam int OW    = RW + 1;                           // after pivot re-add
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (TRIG_FRAC - 1);
  localparam logic signed [OW-1:0] SAT_MAX = OW'(32767);
  localparam logic signed [OW-1:0] SAT_MIN = -OW'(32768);

  // Table index for one angle: the quadrant folds the quarter wave
  function automatic logic [IW-1:0] rom_index(input logic [ANGLE_W-1:0] a);
    logic [PW-1:0] p;
    logic [IW-1:0] i;
    p = PW'(a[QUAD_LSB-1:0]) * PW'(SINE_TABLE_DEPTH);
    i = p[PW-1:QUAD_LSB];
    return a[QUAD_LSB] ? IW'(SINE_TABLE_DEPTH) - i : i;
  endfunction

  // Signed Q1.14 value from table magnitude and sign flag
  function automatic logic signed [TRIG_W:0] apply_sign(input logic [TRIG_W-1:0] m,
                                                        input logic neg);
    logic signed [TRIG_W:0] v;
    v = $signed({1'b0, m});
    return neg ? -v : v;
  endfunction

  // Divide by 16384, rounding half up
  function automatic logic signed [RW-1:0] scale_down(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + ROUND_HALF) >>> TRIG_FRAC;
    return $signed(t[RW-1:0]);
  endfunction

  function automatic logic signed [15:0] saturate16(input logic signed [OW-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_MAX) begin
      r = 16'sh7fff;
    end else if (v < SAT_MIN) begin
      r = -16'sh8000;
    end else begin
      r = $signed(v[15:0]);
    end
    return r;
  endfunction

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- Stage 1: table read, pivot subtract ----------------
  logic [ANGLE_W-1:0] pitch_u, yaw_u, pitch_cos_a, yaw_cos_a;
  logic [TRIG_W-1:0]  ps_mag, pc_mag, ys_mag, yc_mag;
  logic signed [PIV_W-1:0] px_in, py_in;
  logic part_ok;

  assign pitch_u     = pitch_angle;
  assign yaw_u       = yaw_angle;
  assign pitch_cos_a = pitch_u + QUARTER_TURN;
  assign yaw_cos_a   = yaw_u + QUARTER_TURN;
  assign part_ok     = part < PART_W'(NUM_PARTS);

  always_comb begin
    px_in = '0;
    py_in = '0;
    if (part_ok) begin
      px_in = PIV_W'(PIVOT_X_EIGHTHS[part]) <<< (COORD_FRAC_BITS - 3);
      py_in = PIV_W'(PIVOT_Y_EIGHTHS[part]) <<< (COORD_FRAC_BITS - 3);
    end
  end

  lvpr_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_ps (
    .clk(clk), .idx(rom_index(pitch_u)), .mag(ps_mag));
  lvpr_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_pc (
    .clk(clk), .idx(rom_index(pitch_cos_a)), .mag(pc_mag));
  lvpr_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_ys (
    .clk(clk), .idx(rom_index(yaw_u)), .mag(ys_mag));
  lvpr_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom_yc (
    .clk(clk), .idx(rom_index(yaw_cos_a)), .mag(yc_mag));

  logic v1, pitch_on1, yaw_on1;
  logic ps_neg1, pc_neg1, ys_neg1, yc_neg1;
  logic signed [CW-1:0] x1, y1, z1;
  logic signed [PIV_W-1:0] px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    pitch_on1 <= pitch_u != '0;
    yaw_on1   <= (part == PART_HEAD) && (yaw_u != '0);
    ps_neg1   <= pitch_u[ANGLE_W-1];
    pc_neg1   <= pitch_cos_a[ANGLE_W-1];
    ys_neg1   <= yaw_u[ANGLE_W-1];
    yc_neg1   <= yaw_cos_a[ANGLE_W-1];
    x1        <= CW'(x_in) - CW'(px_in);
    y1        <= CW'(y_in) - CW'(py_in);
    z1        <= CW'(z_in);
    px1       <= px_in;
    py1       <= py_in;
  end

  // ---------------- Stage 2: pitch products ----------------
  logic signed [TRIG_W:0] ps_val, pc_val;
  assign ps_val = apply_sign(ps_mag, ps_neg1);
  assign pc_val = apply_sign(pc_mag, pc_neg1);

  logic v2, pitch_on2, yaw_on2;
  logic signed [TRIG_W:0] ys2, yc2;
  logic signed [CW-1:0] x2, y2, z2;
  logic signed [PIV_W-1:0] px2, py2;
  logic signed [PRW-1:0] cy2, sz2, sy2, cz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    pitch_on2 <= pitch_on1;
    yaw_on2   <= yaw_on1;
    ys2       <= apply_sign(ys_mag, ys_neg1);
    yc2       <= apply_sign(yc_mag, yc_neg1);
    x2        <= x1;
    y2        <= y1;
    z2        <= z1;
    px2       <= px1;
    py2       <= py1;
    cy2       <= PRW'(pc_val) * PRW'(y1);
    sz2       <= PRW'(ps_val) * PRW'(z1);
    sy2       <= PRW'(ps_val) * PRW'(y1);
    cz2       <= PRW'(pc_val) * PRW'(z1);
  end

  // ---------------- Stage 3: pitch sum and round ----------------
  logic v3, yaw_on3;
  logic signed [TRIG_W:0] ys3, yc3;
  logic signed [RW-1:0] x3, y3, z3;
  logic signed [PIV_W-1:0] px3, py3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    yaw_on3 <= yaw_on2;
    ys3     <= ys2;
    yc3     <= yc2;
    px3     <= px2;
    py3     <= py2;
    x3      <= RW'(x2);
    if (pitch_on2) begin
      y3 <= scale_down(SW'(cy2) - SW'(sz2));
      z3 <= scale_down(SW'(sy2) + SW'(cz2));
    end else begin
      y3 <= RW'(y2);
      z3 <= RW'(z2);
    end
  end

  // ---------------- Stage 4: yaw products ----------------
  logic v4, yaw_on4;
  logic signed [RW-1:0] x4, y4, z4;
  logic signed [PIV_W-1:0] px4, py4;
  logic signed [PRW-1:0] cx4, sz4, cz4, sx4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    yaw_on4 <= yaw_on3;
    x4      <= x3;
    y4      <= y3;
    z4      <= z3;
    px4     <= px3;
    py4     <= py3;
    cx4     <= PRW'(yc3) * PRW'(x3);
    sz4     <= PRW'(ys3) * PRW'(z3);
    cz4     <= PRW'(yc3) * PRW'(z3);
    sx4     <= PRW'(ys3) * PRW'(x3);
  end

  // ---------------- Stage 5: yaw sum and round ----------------
  logic v5;
  logic signed [RW-1:0] x5, y5, z5;
  logic signed [PIV_W-1:0] px5, py5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    y5  <= y4;
    px5 <= px4;
    py5 <= py4;
    if (yaw_on4) begin
      x5 <= scale_down(SW'(cx4) + SW'(sz4));
      z5 <= scale_down(SW'(cz4) - SW'(sx4));
    end else begin
      x5 <= x4;
      z5 <= z4;
    end
  end

  // ---------------- Stage 6: pivot re-add, saturate ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    x_out <= saturate16(OW'(x5) + OW'(px5));
    y_out <= saturate16(OW'(y5) + OW'(py5));
    z_out <= saturate16(OW'(z5));
  end

endmodule
